@@ src/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, codes and control types of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Number of slots. It must be a power of two, at least 4.
  localparam int SLOTS_DEF = 256;

  localparam int KEY_W  = 32;
  localparam int HASH_W = 32;
  localparam int VAL_W  = 64;
  localparam int TYPE_W = 32;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  // Input tdata: key_id, key_hash, value_in, type_in.
  localparam int IN_DATA_W  = 160;
  // Output tdata: value_out, type_out.
  localparam int OUT_DATA_W = 96;
  // Output tuser: status, is_new_key.
  localparam int OUT_USER_W = 3;

  localparam logic [OP_W-1:0] OP_GET = 2'd0;
  localparam logic [OP_W-1:0] OP_SET = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  // Kind of result the datapath places in the output register.
  localparam logic [2:0] RES_MISS = 3'd0;
  localparam logic [2:0] RES_FULL = 3'd1;
  localparam logic [2:0] RES_GET  = 3'd2;
  localparam logic [2:0] RES_SET  = 3'd3;
  localparam logic [2:0] RES_DONE = 3'd4;

  typedef struct packed {
    logic       accept;
    logic       clr_step;
    logic       rd_issue;
    logic       check;
    logic       val_rd;
    logic       commit_set;
    logic       commit_del;
    logic       out_load;
    logic [2:0] out_kind;
  } lpht_cmd_t;

  typedef struct packed {
    logic            clr_last;
    logic [OP_W-1:0] in_op;
    logic            in_key_zero;
    logic            used_zero;
    logic            over_limit;
    logic            probe_done;
    logic            fnd_ok;
    logic            fnd_hit;
    logic [OP_W-1:0] req_op;
    logic            out_free;
  } lpht_sts_t;

endpackage

@@ src/linear_probe_hash_table.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value map with linear probing and tombstones.
//
//   Channel  Direction  tdata                                   tuser
//   s_*      in         key_id, key_hash, value_in, type_in     op
//   m_*      out        value_out, type_out                     status, is_new_key
//
// After reset a clearing pass writes every key slot with s_tready low. An
// operation is accepted in S_IDLE; each slot probed takes a registered read
// of the key memory (S_READ) and a check (S_CHECK); S_COMMIT then commits a set
// or delete or reads a get's value, and S_RESULT loads the result. A zero key,
// an unused op, a get or delete on an empty table or a set at the load limit
// skips the probe and goes straight from acceptance to S_RESULT.
// The output register holds a result until m_tready; while it waits the
// next transaction is accepted and runs up to its own result.
// ----------------------------------------------------------------------------
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // key_id, key_hash, value_in, type_in
  input  logic [OP_W-1:0]       s_tuser,   // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // value_out, type_out
  output logic [OUT_USER_W-1:0] m_tuser    // status, is_new_key
);

  lpht_cmd_t cmd;
  lpht_sts_t sts;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpht_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ src/lpht_dp.sv @@
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: slot memories, probe index, occupancy count and output register.
// ----------------------------------------------------------------------------
module lpht_dp import lpht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lpht_cmd_t             cmd,
  output lpht_sts_t             sts,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // key_id, key_hash, value_in, type_in
  input  logic [OP_W-1:0]       s_tuser,   // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // value_out, type_out
  output logic [OUT_USER_W-1:0] m_tuser    // status, is_new_key
);

  localparam int IW = $clog2(SLOTS);
  localparam int UW = IW + 1;
  localparam logic [UW-1:0] LIMIT = UW'((SLOTS * 3) / 4);

  logic [KEY_W-1:0]  in_key;
  logic [HASH_W-1:0] in_hash;
  logic [VAL_W-1:0]  in_val;
  logic [TYPE_W-1:0] in_type;

  assign in_key  = s_tdata[31:0];
  assign in_hash = s_tdata[63:32];
  assign in_val  = s_tdata[127:64];
  assign in_type = s_tdata[159:128];

  logic [OP_W-1:0]   req_op;
  logic [KEY_W-1:0]  req_key;
  logic [VAL_W-1:0]  req_val;
  logic [TYPE_W-1:0] req_type;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     n;
  logic              tomb_found;
  logic [IW-1:0]     tomb_idx;
  logic              fnd_ok;
  logic              fnd_hit;
  logic              fnd_tomb;
  logic [IW-1:0]     fnd_idx;
  logic              is_new;
  logic [UW-1:0]     used_count;
  logic [IW-1:0]     clr_idx;

  // Key memory entry: tombstone bit above the key.
  logic [KEY_W:0]              kmem [SLOTS];
  logic [KEY_W:0]              kq;
  logic [VAL_W+TYPE_W-1:0]     vmem [SLOTS];
  logic [VAL_W+TYPE_W-1:0]     vq;

  logic              kwe;
  logic [IW-1:0]     kwa;
  logic [KEY_W:0]    kwd;

  always_comb begin
    kwe = 1'b0;
    kwa = fnd_idx;
    kwd = '0;
    if (cmd.clr_step) begin
      kwe = 1'b1;
      kwa = clr_idx;
    end else if (cmd.commit_set) begin
      kwe = 1'b1;
      kwd = {1'b0, req_key};
    end else if (cmd.commit_del) begin
      kwe = 1'b1;
      kwd = {1'b1, {KEY_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (kwe) begin
      kmem[kwa] <= kwd;
    end
    if (cmd.rd_issue) begin
      kq <= kmem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_set) begin
      vmem[fnd_idx] <= {req_type, req_val};
    end
    if (cmd.val_rd) begin
      vq <= vmem[fnd_idx];
    end
  end

  logic slot_empty;
  logic slot_match;
  logic probe_last;

  assign slot_empty = (kq[KEY_W-1:0] == '0) && !kq[KEY_W];
  assign slot_match = (kq[KEY_W-1:0] == req_key);
  assign probe_last = (n == IW'(SLOTS - 1));

  // Request and probe registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op   <= s_tuser;
      req_key  <= in_key;
      req_val  <= in_val;
      req_type <= in_type;
      idx      <= in_hash[IW-1:0];
      n        <= '0;
    end else if (cmd.check && !(slot_match || slot_empty || probe_last)) begin
      idx <= idx + 1'b1;
      n   <= n + 1'b1;
    end
    if (cmd.check) begin
      if (slot_match) begin
        fnd_ok   <= 1'b1;
        fnd_hit  <= 1'b1;
        fnd_tomb <= 1'b0;
        fnd_idx  <= idx;
      end else if (slot_empty) begin
        fnd_ok   <= 1'b1;
        fnd_hit  <= 1'b0;
        fnd_tomb <= tomb_found;
        fnd_idx  <= tomb_found ? tomb_idx : idx;
      end else if (probe_last) begin
        // Whole table walked: fall back on the first tombstone, if any.
        fnd_ok   <= tomb_found | kq[KEY_W];
        fnd_hit  <= 1'b0;
        fnd_tomb <= 1'b1;
        fnd_idx  <= tomb_found ? tomb_idx : idx;
      end
    end
    if (cmd.check && kq[KEY_W] && !tomb_found) begin
      tomb_idx <= idx;
    end
    if (cmd.commit_set) begin
      is_new <= !fnd_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tomb_found <= 1'b0;
    end else if (cmd.accept) begin
      tomb_found <= 1'b0;
    end else if (cmd.check && kq[KEY_W]) begin
      tomb_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      clr_idx    <= '0;
    end else begin
      if (cmd.commit_set && !fnd_hit && !fnd_tomb) begin
        used_count <= used_count + 1'b1;
      end
      if (cmd.clr_step) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_kind)
        RES_GET: begin
          m_tdata <= vq;
          m_tuser <= {1'b0, ST_DONE};
        end
        RES_SET: begin
          m_tdata <= '0;
          m_tuser <= {is_new, ST_DONE};
        end
        RES_DONE: begin
          m_tdata <= '0;
          m_tuser <= {1'b0, ST_DONE};
        end
        RES_FULL: begin
          m_tdata <= '0;
          m_tuser <= {1'b0, ST_FULL};
        end
        default: begin
          m_tdata <= '0;
          m_tuser <= {1'b0, ST_MISSING};
        end
      endcase
    end
  end

  always_comb begin
    sts.clr_last    = (clr_idx == IW'(SLOTS - 1));
    sts.in_op       = s_tuser;
    sts.in_key_zero = (in_key == '0);
    sts.used_zero   = (used_count == '0);
    sts.over_limit  = (used_count >= LIMIT);
    sts.probe_done  = slot_match | slot_empty | probe_last;
    sts.fnd_ok      = fnd_ok;
    sts.fnd_hit     = fnd_hit;
    sts.req_op      = req_op;
    sts.out_free    = !m_tvalid || m_tready;
  end

endmodule

@@ src/lpht_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller: clearing pass, probe sequencing and result hand-off.
// ----------------------------------------------------------------------------
module lpht_ctrl import lpht_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  lpht_sts_t sts,
  output lpht_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] res_kind;
  logic [2:0] res_kind_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    res_kind_next = res_kind;
    cmd           = '0;
    cmd.out_kind  = res_kind;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
          if (sts.in_key_zero) begin
            res_kind_next = RES_MISS;
            state_next    = S_RESULT;
          end else begin
            case (sts.in_op)
              OP_GET, OP_DEL: begin
                if (sts.used_zero) begin
                  res_kind_next = RES_MISS;
                  state_next    = S_RESULT;
                end
              end
              OP_SET: begin
                if (sts.over_limit) begin
                  res_kind_next = RES_FULL;
                  state_next    = S_RESULT;
                end
              end
              default: begin
                res_kind_next = RES_MISS;
                state_next    = S_RESULT;
              end
            endcase
          end
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.probe_done ? S_COMMIT : S_READ;
      end
      S_COMMIT: begin
        state_next = S_RESULT;
        case (sts.req_op)
          OP_GET: begin
            if (sts.fnd_hit) begin
              cmd.val_rd    = 1'b1;
              res_kind_next = RES_GET;
            end else begin
              res_kind_next = RES_MISS;
            end
          end
          OP_SET: begin
            if (sts.fnd_ok) begin
              cmd.commit_set = 1'b1;
              res_kind_next  = RES_SET;
            end else begin
              res_kind_next = RES_FULL;
            end
          end
          default: begin
            if (sts.fnd_hit) begin
              cmd.commit_del = 1'b1;
              res_kind_next  = RES_DONE;
            end else begin
              res_kind_next = RES_MISS;
            end
          end
        endcase
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      res_kind <= RES_MISS;
    end else begin
      state    <= state_next;
      res_kind <= res_kind_next;
    end
  end

endmodule

@@ src/lpht_checker.sv @@
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table's handshakes and result codes.
// ----------------------------------------------------------------------------
module lpht_assertions import lpht_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser
);

  // Nothing comes out of reset as a pending result.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // One operation at a time: input closes after each transaction.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready again right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[1:0] == ST_DONE || m_tuser[1:0] == ST_MISSING ||
                  m_tuser[1:0] == ST_FULL))
    else $error("unknown status code");

  // A new key is only reported by a successful operation.
  a_new_key_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == ST_DONE && m_tdata == '0))
    else $error("new key flag on a failed or get result");

endmodule

bind linear_probe_hash_table lpht_assertions u_lpht_assertions (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ tb/lpht_checker.sv @@
// ----------------------------------------------------------------------------
// lpht_checker
// Watches both stream channels of the hash table. Every accepted request
// transaction updates a shadow table and queues the expected response; every
// accepted response transaction is compared with the oldest queued response.
// ----------------------------------------------------------------------------
module lpht_checker import lpht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [OP_W-1:0]       s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic [OUT_USER_W-1:0] m_tuser,
  output int                    pending,
  output int                    fail_count
);

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic              is_new;
    logic [VAL_W-1:0]  value;
    logic [TYPE_W-1:0] tag;
  } resp_t;

  localparam int LOAD_LIMIT = (SLOTS * 3) / 4;

  logic [KEY_W-1:0]  shadow_key  [SLOTS];
  logic              shadow_tomb [SLOTS];
  logic [VAL_W-1:0]  shadow_val  [SLOTS];
  logic [TYPE_W-1:0] shadow_type [SLOTS];
  int                shadow_used;
  resp_t             resp_queue[$];

  // Returns the matching slot, the slot a set would fill, or SLOTS for none.
  function automatic int find_slot(logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash);
    int idx;
    int tomb;
    idx  = int'(hash % SLOTS);
    tomb = SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      if (shadow_key[idx] == '0) begin
        if (!shadow_tomb[idx]) return (tomb != SLOTS) ? tomb : idx;
        if (tomb == SLOTS) tomb = idx;
      end else if (shadow_key[idx] == key) begin
        return idx;
      end
      idx = (idx + 1) % SLOTS;
    end
    return tomb;
  endfunction

  function automatic resp_t apply_request(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] d);
    resp_t r;
    int idx;
    logic [KEY_W-1:0] key;
    logic [HASH_W-1:0] hash;
    key  = d[31:0];
    hash = d[63:32];
    r = '{status: ST_MISSING, is_new: 1'b0, value: '0, tag: '0};
    if (key != '0) begin
      if (op == OP_GET) begin
        if (shadow_used != 0) begin
          idx = find_slot(key, hash);
          if (idx < SLOTS && shadow_key[idx] == key) begin
            r.status = ST_DONE;
            r.value  = shadow_val[idx];
            r.tag    = shadow_type[idx];
          end
        end
      end else if (op == OP_SET) begin
        r.status = ST_FULL;
        if (shadow_used + 1 <= LOAD_LIMIT) begin
          idx = find_slot(key, hash);
          if (idx < SLOTS) begin
            r.is_new = (shadow_key[idx] != key);
            if (r.is_new && !shadow_tomb[idx]) shadow_used++;
            shadow_key[idx]  = key;
            shadow_tomb[idx] = 1'b0;
            shadow_val[idx]  = d[127:64];
            shadow_type[idx] = d[159:128];
            r.status = ST_DONE;
          end
        end
      end else if (op == OP_DEL) begin
        if (shadow_used != 0) begin
          idx = find_slot(key, hash);
          if (idx < SLOTS && shadow_key[idx] == key) begin
            shadow_key[idx]  = '0;
            shadow_tomb[idx] = 1'b1;
            shadow_val[idx]  = '0;
            shadow_type[idx] = '0;
            r.status = ST_DONE;
          end
        end
      end
    end
    return r;
  endfunction

  assign pending = resp_queue.size();

  always @(posedge clk) begin
    resp_t exp_r;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        shadow_key[i]  = '0;
        shadow_tomb[i] = 1'b0;
        shadow_val[i]  = '0;
        shadow_type[i] = '0;
      end
      shadow_used = 0;
      fail_count  <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (resp_queue.size() == 0) begin
          $error("response transaction with nothing expected: tuser %h tdata %h",
                 m_tuser, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = resp_queue.pop_front();
          if (m_tuser[1:0] !== exp_r.status ||
              m_tuser[2] !== exp_r.is_new ||
              m_tdata[63:0] !== exp_r.value ||
              m_tdata[95:64] !== exp_r.tag) begin
            fail_count <= fail_count + 1;
            if (m_tuser[1:0] !== exp_r.status)
              $error("status: expected %0d, actual %0d", exp_r.status, m_tuser[1:0]);
            if (m_tuser[2] !== exp_r.is_new)
              $error("is_new_key: expected %0d, actual %0d", exp_r.is_new, m_tuser[2]);
            if (m_tdata[63:0] !== exp_r.value)
              $error("value_out: expected %h, actual %h", exp_r.value, m_tdata[63:0]);
            if (m_tdata[95:64] !== exp_r.tag)
              $error("type_out: expected %h, actual %h", exp_r.tag, m_tdata[95:64]);
          end
        end
      end
      // The request is predicted after the pop so a same-cycle response
      // never matches its own request.
      if (s_tvalid && s_tready) resp_queue.push_back(apply_request(s_tuser, s_tdata));
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the linear probing hash table. Directed requests
// cover empty table, zero key, unused op, overwrite, collisions, tombstone
// reuse and extreme values; random phases then work a clustered key pool
// up to the load limit under varied source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import lpht_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int POOL_SIZE      = 220;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = OP_GET;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  int                    pending;
  int                    fail_count;
  int                    idle_pct  = 0;
  int                    stall_pct = 0;
  int                    quiet_cycles = 0;
  logic [KEY_W-1:0]      pool_key  [POOL_SIZE];
  logic [HASH_W-1:0]     pool_hash [POOL_SIZE];

  always #5 clk = ~clk;

  linear_probe_hash_table u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  lpht_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .pending(pending), .fail_count(fail_count)
  );

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Holds one request transaction until accepted. Valid stays high into the
  // next request unless the source decides to idle first.
  task automatic send_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                          logic [HASH_W-1:0] hash, logic [VAL_W-1:0] val,
                          logic [TYPE_W-1:0] tag);
    logic ready_seen;
    if ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {tag, val, hash, key};
    do begin
      @(negedge clk);
      ready_seen = s_tready;
      @(posedge clk);
    end while (!ready_seen);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_phase(int items, int pool_used);
    int sel;
    int k;
    logic [OP_W-1:0] op;
    for (int i = 0; i < items; i++) begin
      sel = $urandom_range(0, 99);
      k   = $urandom_range(0, pool_used - 1);
      op  = (sel < 40) ? OP_SET : (sel < 75) ? OP_GET : OP_DEL;
      if (sel >= 95)
        send_req((sel & 1) ? OP_UNUSED : op, (sel & 1) ? $urandom : '0, $urandom,
                 {$urandom, $urandom}, $urandom);
      else if ($urandom_range(0, 99) < 85)
        send_req(op, pool_key[k], pool_hash[k], {$urandom, $urandom}, $urandom);
      else
        send_req(op, $urandom | 32'h1, $urandom, {$urandom, $urandom}, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_key[i]  = $urandom | 32'h8000_0000;
      pool_hash[i] = ($urandom & 32'hFFFF_FF00) | 32'($urandom_range(0, 31));
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    send_req(OP_GET, 32'h11, 32'h10, '0, '0);
    send_req(OP_DEL, 32'h11, 32'h10, '0, '0);
    send_req(OP_SET, '0, 32'h10, '1, '1);
    send_req(OP_UNUSED, 32'h11, 32'h10, '1, '1);
    send_req(OP_SET, 32'h11, 32'h10, '1, '1);
    send_req(OP_GET, 32'h11, 32'h10, '0, '0);
    send_req(OP_SET, 32'h11, 32'h10, 64'h0123_4567_89ab_cdef, 32'h5a5a_a5a5);
    send_req(OP_GET, 32'h11, 32'h10, '0, '0);
    send_req(OP_SET, 32'h22, 32'h110, '0, '0);
    send_req(OP_SET, '1, '1, '1, '1);
    send_req(OP_GET, 32'h22, 32'h110, '0, '0);
    send_req(OP_DEL, 32'h11, 32'h10, '0, '0);
    send_req(OP_GET, 32'h11, 32'h10, '0, '0);
    send_req(OP_GET, 32'h22, 32'h110, '0, '0);
    send_req(OP_SET, 32'h33, 32'h10, 64'h1, 32'h2);
    send_req(OP_GET, 32'h33, 32'h10, '0, '0);
    send_req(OP_DEL, 32'h44, 32'h10, '0, '0);
    send_req(OP_GET, 32'h44, 32'h11, '0, '0);
    send_req(OP_GET, '1, '1, '0, '0);
    send_req(OP_DEL, '0, '1, '0, '0);
    send_req(OP_DEL, '1, '1, '0, '0);
    send_req(OP_GET, '1, '1, '0, '0);
    drain();

    // Random phases; the pool grows so the last phase runs into the load limit.
    idle_pct = 0;  stall_pct = 0;  random_phase(180, 70);
    drain();
    idle_pct = 87; stall_pct = 0;  random_phase(180, 120);
    idle_pct = 0;  stall_pct = 87; random_phase(180, 170);
    drain();
    idle_pct = 27; stall_pct = 27; random_phase(190, POOL_SIZE);

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
src/lpht_pkg.sv
src/lpht_dp.sv
src/lpht_ctrl.sv
src/linear_probe_hash_table.sv
src/lpht_checker.sv
tb/lpht_checker.sv
tb/tb.sv
